@@ hdl/hcpf_pkg.sv @@
// shared constants and types for the hertz contact pair force pipeline
// no dependencies; used by every module under hdl
`timescale 1ns / 1ps

package hcpf_pkg;

    // field widths
    localparam int POS_W    = 32;
    localparam int RAD_W    = 31;
    localparam int DIFF_W   = POS_W + 1;
    localparam int FORCE_W  = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int STATUS_W = 2;

    // default of the axis count
    localparam int DIMENSIONS_DEFAULT = 3;

    // arithmetic unit sizes
    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_OUT_W = SQRT_IN_W / 2;
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 32;
    localparam int UNIT_Q_W   = 32;
    localparam int MAG_Q_W    = 64;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFORMATION_ENERGY = 2'd0,
        CFG_USE_CUTOFF         = 2'd1,
        CFG_CUTOFF_LENGTH      = 2'd2
    } cfg_index_t;

    // configuration reset values
    localparam logic [CFG_W-1:0] DEFORMATION_RESET = 32'd17476;
    localparam logic [CFG_W-1:0] CUTOFF_RESET      = 32'hFFFF_FFFF;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_COINCIDENT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SATURATED  = 2'd2;

endpackage

@@ hdl/hcpf_delay.sv @@
// shift line that carries a valid bit and a sideband word alongside a unit
// depends on hcpf_pkg for default sizes
`timescale 1ns / 1ps

module hcpf_delay #(
    parameter int DATA_W = hcpf_pkg::CFG_W,
    parameter int DEPTH  = hcpf_pkg::SQRT_OUT_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    output logic [DATA_W-1:0] out_data
);

    logic              valid_reg [DEPTH];
    logic [DATA_W-1:0] data_reg  [DEPTH];

    // valid bits, cleared on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < DEPTH; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // sideband words
    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg[0] <= in_data;
            for (int k = 1; k < DEPTH; k++) begin
                data_reg[k] <= data_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

@@ hdl/hcpf_sqrt.sv @@
// pipelined integer square root, one result bit per register stage
// depends on hcpf_pkg for default sizes
`timescale 1ns / 1ps

module hcpf_sqrt #(
    parameter int IN_W = hcpf_pkg::SQRT_IN_W
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [IN_W-1:0]   radicand,
    output logic [IN_W/2-1:0] root
);

    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 1;

    logic [REM_W-1:0] rem_reg  [OUT_W];
    logic [OUT_W-1:0] root_reg [OUT_W];
    logic [IN_W-1:0]  rad_reg  [OUT_W];

    for (genvar k = 0; k < OUT_W; k++) begin : g_step
        logic [REM_W-1:0] rem_in;
        logic [OUT_W-1:0] root_in;
        logic [IN_W-1:0]  rad_in;
        logic [REM_W+1:0] trial_rem;
        logic [REM_W+1:0] trial_sub;
        logic             take;
        logic [REM_W-1:0] rem_next;
        logic [OUT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        // bring down two radicand bits and try to subtract 4*root+1
        always_comb begin
            trial_rem = {rem_in, rad_in[IN_W-1-2*k -: 2]};
            trial_sub = {1'b0, root_in, 2'b01};
            take      = (trial_rem >= trial_sub);
            rem_next  = take ? REM_W'(trial_rem - trial_sub) : REM_W'(trial_rem);
            root_next = {root_in[OUT_W-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_in;
            end
        end
    end

    assign root = root_reg[OUT_W-1];

endmodule

@@ hdl/hcpf_div.sv @@
// pipelined restoring divider, one quotient bit per register stage
// depends on hcpf_pkg for default sizes; quotient must fit in QUO_W bits
`timescale 1ns / 1ps

module hcpf_div #(
    parameter int NUM_W = hcpf_pkg::DIV_NUM_W,
    parameter int DEN_W = hcpf_pkg::DIV_DEN_W,
    parameter int QUO_W = hcpf_pkg::UNIT_Q_W
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] numerator,
    input  logic [DEN_W-1:0] denominator,
    output logic [QUO_W-1:0] quotient
);

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [QUO_W-1:0] num_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [QUO_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic             take;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (k == 0) begin : g_first
            // upper numerator bits start the remainder
            assign rem_in = DEN_W'(numerator >> QUO_W);
            assign quo_in = '0;
            assign num_in = numerator[QUO_W-1:0];
            assign den_in = denominator;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign num_in = num_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        // shift in the next numerator bit and compare against the divisor
        always_comb begin
            trial    = {rem_in, num_in[QUO_W-1-k]};
            take     = (trial >= {1'b0, den_in});
            rem_next = take ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
            quo_next = {quo_in[QUO_W-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                num_reg[k] <= num_in;
                den_reg[k] <= den_in;
            end
        end
    end

    assign quotient = quo_reg[QUO_W-1];

endmodule

@@ hdl/hertz_contact_pair_force.sv @@
// top level of the hertz contact pair force pipeline
// depends on hcpf_pkg, hcpf_delay, hcpf_sqrt and hcpf_div
`timescale 1ns / 1ps

// Hertzian contact force between two spherical cells; positions and forces are
// signed Q16.16, and each result is the force on the first cell. One cell pair
// enters per clock; the whole pipeline moves together, so a stall at the result
// side freezes every stage and s_ready follows (no result is lost or repeated).
// The pipeline is built around a chain of bit-per-stage units: a 32-stage square
// root for the distance, 32-stage dividers for the unit vector and effective radius,
// a second 32-stage root, and a 64-stage division of the magnitude by the deformation
// energy. Configuration writes are taken on any cycle and must only happen while
// the pipeline is empty. There is no clearing pass after reset.
module hertz_contact_pair_force #(
    parameter int DIMENSIONS = hcpf_pkg::DIMENSIONS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hcpf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hcpf_pkg::CFG_W-1:0]           cfg_data,
    // pair input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [hcpf_pkg::POS_W-1:0]    s_a_x,
    input  logic signed [hcpf_pkg::POS_W-1:0]    s_a_y,
    input  logic signed [hcpf_pkg::POS_W-1:0]    s_a_z,
    input  logic signed [hcpf_pkg::POS_W-1:0]    s_b_x,
    input  logic signed [hcpf_pkg::POS_W-1:0]    s_b_y,
    input  logic signed [hcpf_pkg::POS_W-1:0]    s_b_z,
    input  logic [hcpf_pkg::RAD_W-1:0]           s_radius_a,
    input  logic [hcpf_pkg::RAD_W-1:0]           s_radius_b,
    // force output channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [hcpf_pkg::FORCE_W-1:0]  m_force_x,
    output logic signed [hcpf_pkg::FORCE_W-1:0]  m_force_y,
    output logic signed [hcpf_pkg::FORCE_W-1:0]  m_force_z,
    output logic [hcpf_pkg::STATUS_W-1:0]        m_status
);

    localparam int PW  = hcpf_pkg::POS_W;
    localparam int DW  = hcpf_pkg::DIFF_W;
    localparam int RW  = hcpf_pkg::RAD_W;
    localparam int CW  = hcpf_pkg::CFG_W;
    localparam int SW  = hcpf_pkg::SQRT_IN_W;
    localparam int QW  = hcpf_pkg::SQRT_OUT_W;
    localparam int FW  = hcpf_pkg::FORCE_W;
    localparam int MW  = hcpf_pkg::MAG_Q_W;
    localparam int UW  = hcpf_pkg::UNIT_Q_W;
    localparam int NW  = hcpf_pkg::DIV_NUM_W;
    localparam int PRW = 2 * RW;
    localparam int FULL_W = MW + UW - 31;

    localparam logic [FULL_W-1:0] POS_LIMIT = FULL_W'(33'h0_7FFF_FFFF);
    localparam logic [FULL_W-1:0] NEG_LIMIT = FULL_W'(33'h0_8000_0000);

    typedef struct packed {
        logic                kill;
        logic                coin;
        logic [2:0]          neg;
        logic [2:0][PW-1:0]  mag;
        logic [PW-1:0]       rsum;
        logic [PRW-1:0]      rprod;
    } root_side_t;

    typedef struct packed {
        logic                kill;
        logic                coin;
        logic [2:0]          neg;
        logic [PW-1:0]       delta;
    } div_side_t;

    typedef struct packed {
        logic                kill;
        logic                coin;
        logic [2:0]          neg;
        logic [2:0][UW-1:0]  u;
        logic [PW-1:0]       delta;
    } sq_side_t;

    typedef struct packed {
        logic                kill;
        logic                coin;
        logic [2:0]          neg;
        logic [2:0][UW-1:0]  u;
    } mag_side_t;

    logic pipe_en;

    // configuration registers
    logic [CW-1:0] energy_reg;
    logic          use_cutoff_reg;
    logic [CW-1:0] cutoff_reg;
    logic [CW-1:0] energy_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg     <= hcpf_pkg::DEFORMATION_RESET;
            use_cutoff_reg <= 1'b0;
            cutoff_reg     <= hcpf_pkg::CUTOFF_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                hcpf_pkg::CFG_DEFORMATION_ENERGY: energy_reg     <= cfg_data;
                hcpf_pkg::CFG_USE_CUTOFF:         use_cutoff_reg <= cfg_data[0];
                hcpf_pkg::CFG_CUTOFF_LENGTH:      cutoff_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // zero energy acts as the smallest step
    assign energy_eff = (energy_reg == '0) ? CW'(1) : energy_reg;

    // whole pipeline advances unless a result is held
    logic out_valid_reg;
    assign pipe_en = !out_valid_reg || m_ready;
    assign s_ready = pipe_en;

    // stage 1: axis differences and magnitudes
    logic signed [PW-1:0] pos_a [3];
    logic signed [PW-1:0] pos_b [3];
    logic [DW-1:0]        mag_next [3];
    logic                 neg_next [3];

    assign pos_a[0] = s_a_x;
    assign pos_a[1] = s_a_y;
    assign pos_a[2] = s_a_z;
    assign pos_b[0] = s_b_x;
    assign pos_b[1] = s_b_y;
    assign pos_b[2] = s_b_z;

    for (genvar i = 0; i < 3; i++) begin : g_axis
        if (i < DIMENSIONS) begin : g_used
            logic signed [DW-1:0] diff;
            assign diff        = {pos_b[i][PW-1], pos_b[i]} - {pos_a[i][PW-1], pos_a[i]};
            assign mag_next[i] = diff[DW-1] ? DW'(-diff) : DW'(diff);
            assign neg_next[i] = !diff[DW-1] && (diff != '0);
        end else begin : g_unused
            assign mag_next[i] = '0;
            assign neg_next[i] = 1'b0;
        end
    end

    logic          v1_reg;
    logic [DW-1:0] mag1_reg [3];
    logic [2:0]    neg1_reg;
    logic [RW-1:0] r1_reg;
    logic [RW-1:0] r2_reg;
    logic [PW-1:0] rsum1_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                mag1_reg[i] <= mag_next[i];
                neg1_reg[i] <= neg_next[i];
            end
            r1_reg    <= s_radius_a;
            r2_reg    <= s_radius_b;
            rsum1_reg <= PW'(s_radius_a) + PW'(s_radius_b);
        end
    end

    // stage 2: squares of the axes, radius sum and cutoff, radius product
    logic          v2_reg;
    logic [SW-1:0] sq2_reg [3];
    logic [SW-1:0] rsq2_reg;
    logic [SW-1:0] csq2_reg;
    logic [PRW-1:0] rprod2_reg;
    logic [PW-1:0] mag2_reg [3];
    logic [2:0]    neg2_reg;
    logic [PW-1:0] rsum2_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                sq2_reg[i]  <= mag1_reg[i][DW-1] ? '1
                             : SW'(mag1_reg[i][PW-1:0] * mag1_reg[i][PW-1:0]);
                mag2_reg[i] <= mag1_reg[i][PW-1:0];
            end
            rsq2_reg   <= SW'(rsum1_reg * rsum1_reg);
            csq2_reg   <= SW'(cutoff_reg * cutoff_reg);
            rprod2_reg <= PRW'(r1_reg * r2_reg);
            neg2_reg   <= neg1_reg;
            rsum2_reg  <= rsum1_reg;
        end
    end

    // stage 3: saturating sum of the first two squares
    logic          v3_reg;
    logic [SW-1:0] s3_reg;
    logic [SW-1:0] sqz3_reg;
    logic [SW-1:0] rsq3_reg;
    logic [SW-1:0] csq3_reg;
    logic [PRW-1:0] rprod3_reg;
    logic [PW-1:0] mag3_reg [3];
    logic [2:0]    neg3_reg;
    logic [PW-1:0] rsum3_reg;
    logic [SW:0]   sum3;

    assign sum3 = {1'b0, sq2_reg[0]} + {1'b0, sq2_reg[1]};

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s3_reg     <= sum3[SW] ? '1 : sum3[SW-1:0];
            sqz3_reg   <= sq2_reg[2];
            rsq3_reg   <= rsq2_reg;
            csq3_reg   <= csq2_reg;
            rprod3_reg <= rprod2_reg;
            mag3_reg   <= mag2_reg;
            neg3_reg   <= neg2_reg;
            rsum3_reg  <= rsum2_reg;
        end
    end

    // stage 4: add the third square
    logic          v4_reg;
    logic [SW-1:0] s4_reg;
    logic [SW-1:0] rsq4_reg;
    logic [SW-1:0] csq4_reg;
    logic [PRW-1:0] rprod4_reg;
    logic [PW-1:0] mag4_reg [3];
    logic [2:0]    neg4_reg;
    logic [PW-1:0] rsum4_reg;
    logic [SW:0]   sum4;

    assign sum4 = {1'b0, s3_reg} + {1'b0, sqz3_reg};

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s4_reg     <= sum4[SW] ? '1 : sum4[SW-1:0];
            rsq4_reg   <= rsq3_reg;
            csq4_reg   <= csq3_reg;
            rprod4_reg <= rprod3_reg;
            mag4_reg   <= mag3_reg;
            neg4_reg   <= neg3_reg;
            rsum4_reg  <= rsum3_reg;
        end
    end

    // stage 5: cutoff, coincidence and contact tests
    logic          v5_reg;
    logic [SW-1:0] s5_reg;
    logic          kill5_reg;
    logic          coin5_reg;
    logic [PRW-1:0] rprod5_reg;
    logic [PW-1:0] mag5_reg [3];
    logic [2:0]    neg5_reg;
    logic [PW-1:0] rsum5_reg;
    logic          cut_hit;
    logic          zero_dist;
    logic          no_contact;

    assign cut_hit    = use_cutoff_reg && (s4_reg >= csq4_reg);
    assign zero_dist  = (s4_reg == '0);
    assign no_contact = (s4_reg >= rsq4_reg);

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s5_reg     <= s4_reg;
            kill5_reg  <= cut_hit || zero_dist || no_contact;
            coin5_reg  <= !cut_hit && zero_dist;
            rprod5_reg <= rprod4_reg;
            mag5_reg   <= mag4_reg;
            neg5_reg   <= neg4_reg;
            rsum5_reg  <= rsum4_reg;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // distance square root
    root_side_t    side1_in;
    root_side_t    side1_out;
    logic          v_r1;
    logic [QW-1:0] dist_root;

    assign side1_in.kill  = kill5_reg;
    assign side1_in.coin  = coin5_reg;
    assign side1_in.neg   = neg5_reg;
    assign side1_in.mag   = {mag5_reg[2], mag5_reg[1], mag5_reg[0]};
    assign side1_in.rsum  = rsum5_reg;
    assign side1_in.rprod = rprod5_reg;

    hcpf_sqrt #(.IN_W(SW)) u_dist_sqrt (
        .aclk     (aclk),
        .en       (pipe_en),
        .radicand (s5_reg),
        .root     (dist_root)
    );

    hcpf_delay #(.DATA_W($bits(root_side_t)), .DEPTH(QW)) u_dist_delay (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (v5_reg),
        .in_data   (side1_in),
        .out_valid (v_r1),
        .out_data  (side1_out)
    );

    // effective radius and unit vector dividers
    div_side_t     side2_in;
    div_side_t     side2_out;
    logic          v_d1;
    logic [UW-1:0] reff;
    logic [UW-1:0] unit [3];

    assign side2_in.kill  = side1_out.kill;
    assign side2_in.coin  = side1_out.coin;
    assign side2_in.neg   = side1_out.neg;
    assign side2_in.delta = side1_out.rsum - dist_root;

    hcpf_div #(.NUM_W(NW), .DEN_W(PW), .QUO_W(UW)) u_reff_div (
        .aclk        (aclk),
        .en          (pipe_en),
        .numerator   (NW'(side1_out.rprod)),
        .denominator (side1_out.rsum),
        .quotient    (reff)
    );

    for (genvar i = 0; i < 3; i++) begin : g_unit
        hcpf_div #(.NUM_W(NW), .DEN_W(QW), .QUO_W(UW)) u_unit_div (
            .aclk        (aclk),
            .en          (pipe_en),
            .numerator   ({1'b0, side1_out.mag[i], 31'd0}),
            .denominator (dist_root),
            .quotient    (unit[i])
        );
    end

    hcpf_delay #(.DATA_W($bits(div_side_t)), .DEPTH(UW)) u_div_delay (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (v_r1),
        .in_data   (side2_in),
        .out_valid (v_d1),
        .out_data  (side2_out)
    );

    // overlap times effective radius
    logic          vm1_reg;
    logic [SW-1:0] p1_reg;
    sq_side_t      side3_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p1_reg          <= SW'(side2_out.delta * reff);
            side3_reg.kill  <= side2_out.kill;
            side3_reg.coin  <= side2_out.coin;
            side3_reg.neg   <= side2_out.neg;
            side3_reg.u     <= {unit[2], unit[1], unit[0]};
            side3_reg.delta <= side2_out.delta;
        end
    end

    // square root of the overlap product
    sq_side_t      side3_out;
    logic          v_r2;
    logic [QW-1:0] root2;

    hcpf_sqrt #(.IN_W(SW)) u_mag_sqrt (
        .aclk     (aclk),
        .en       (pipe_en),
        .radicand (p1_reg),
        .root     (root2)
    );

    hcpf_delay #(.DATA_W($bits(sq_side_t)), .DEPTH(QW)) u_sq_delay (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (vm1_reg),
        .in_data   (side3_reg),
        .out_valid (v_r2),
        .out_data  (side3_out)
    );

    // overlap times root gives the undivided magnitude
    logic          vm2_reg;
    logic [MW-1:0] num_reg;
    mag_side_t     side4_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            num_reg        <= MW'(side3_out.delta * root2);
            side4_reg.kill <= side3_out.kill;
            side4_reg.coin <= side3_out.coin;
            side4_reg.neg  <= side3_out.neg;
            side4_reg.u    <= side3_out.u;
        end
    end

    // divide by the deformation energy
    mag_side_t     side4_out;
    logic          v_d2;
    logic [MW-1:0] mag_force;

    hcpf_div #(.NUM_W(MW), .DEN_W(CW), .QUO_W(MW)) u_energy_div (
        .aclk        (aclk),
        .en          (pipe_en),
        .numerator   (num_reg),
        .denominator (energy_eff),
        .quotient    (mag_force)
    );

    hcpf_delay #(.DATA_W($bits(mag_side_t)), .DEPTH(MW)) u_mag_delay (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (vm2_reg),
        .in_data   (side4_reg),
        .out_valid (v_d2),
        .out_data  (side4_out)
    );

    // partial products of magnitude and unit components
    logic          vm3_reg;
    logic [SW-1:0] ph_reg [3];
    logic [SW-1:0] pl_reg [3];
    logic          kill3m_reg;
    logic          coin3m_reg;
    logic [2:0]    neg3m_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                ph_reg[i] <= SW'(mag_force[MW-1:32] * side4_out.u[i]);
                pl_reg[i] <= SW'(mag_force[31:0] * side4_out.u[i]);
            end
            kill3m_reg <= side4_out.kill;
            coin3m_reg <= side4_out.coin;
            neg3m_reg  <= side4_out.neg;
        end
    end

    // combine partial products and drop the unit fraction
    logic              vm4_reg;
    logic [FULL_W-1:0] full_reg [3];
    logic              kill4m_reg;
    logic              coin4m_reg;
    logic [2:0]        neg4m_reg;
    logic [SW+31:0]    prod [3];

    for (genvar i = 0; i < 3; i++) begin : g_prod
        assign prod[i] = {ph_reg[i], 32'd0} + {32'd0, pl_reg[i]};
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                full_reg[i] <= prod[i][SW+31:31];
            end
            kill4m_reg <= kill3m_reg;
            coin4m_reg <= coin3m_reg;
            neg4m_reg  <= neg3m_reg;
        end
    end

    // saturate, apply sign and pick the status
    logic [FW-1:0]     force_next [3];
    logic [2:0]        sat_next;
    logic [FW-1:0]     force_reg [3];
    logic [hcpf_pkg::STATUS_W-1:0] status_reg;
    logic [hcpf_pkg::STATUS_W-1:0] status_next;

    for (genvar i = 0; i < 3; i++) begin : g_sat
        logic [FULL_W-1:0] limit;
        logic [FW-1:0]     size;
        assign limit         = neg4m_reg[i] ? NEG_LIMIT : POS_LIMIT;
        assign sat_next[i]   = (full_reg[i] > limit);
        assign size          = sat_next[i] ? limit[FW-1:0] : full_reg[i][FW-1:0];
        assign force_next[i] = kill4m_reg ? '0 : (neg4m_reg[i] ? FW'(-size) : size);
    end

    always_comb begin
        if (kill4m_reg) begin
            status_next = coin4m_reg ? hcpf_pkg::STATUS_COINCIDENT : hcpf_pkg::STATUS_OK;
        end else if (sat_next != '0) begin
            status_next = hcpf_pkg::STATUS_SATURATED;
        end else begin
            status_next = hcpf_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            force_reg  <= force_next;
            status_reg <= status_next;
        end
    end

    // valid bits of the back stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm1_reg       <= 1'b0;
            vm2_reg       <= 1'b0;
            vm3_reg       <= 1'b0;
            vm4_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            vm1_reg       <= v_d1;
            vm2_reg       <= v_r2;
            vm3_reg       <= v_d2;
            vm4_reg       <= vm3_reg;
            out_valid_reg <= vm4_reg;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_force_x = force_reg[0];
    assign m_force_y = force_reg[1];
    assign m_force_z = force_reg[2];
    assign m_status  = status_reg;

    // coincident pairs carry no force
    a_coin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == hcpf_pkg::STATUS_COINCIDENT)
        |-> (m_force_x == '0) && (m_force_y == '0) && (m_force_z == '0))
        else $error("coincident pair with nonzero force");

    // a saturated result has at least one nonzero component
    a_sat_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == hcpf_pkg::STATUS_SATURATED)
        |-> (m_force_x != '0) || (m_force_y != '0) || (m_force_z != '0))
        else $error("saturation flagged on a zero force");

    // status never takes the unused code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == hcpf_pkg::STATUS_OK)
                 || (m_status == hcpf_pkg::STATUS_COINCIDENT)
                 || (m_status == hcpf_pkg::STATUS_SATURATED))
        else $error("undefined status code");

    // an unused z axis stays at zero force
    a_unused_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (DIMENSIONS < 3) |-> (m_force_z == '0))
        else $error("force on an unused axis");

    // a stalled pipeline keeps its result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(status_reg) && out_valid_reg)
        else $error("result changed during a stall");

endmodule

@@ tb/tb.sv @@
// self-checking testbench for hertz_contact_pair_force
// depends on hcpf_pkg and the rtl under hdl; no files or arguments needed
`timescale 1ns / 1ps

module tb;

    localparam int DIMS       = 3;
    localparam int DRAIN_WAIT = 400;
    localparam int STUCK_MAX  = 20000;
    localparam int RW         = hcpf_pkg::RAD_W;

    typedef struct {
        logic signed [hcpf_pkg::POS_W-1:0] ax, ay, az, bx, by, bz;
        logic [hcpf_pkg::RAD_W-1:0]        ra, rb;
    } pair_t;

    typedef struct {
        logic signed [hcpf_pkg::FORCE_W-1:0] fx, fy, fz;
        logic [hcpf_pkg::STATUS_W-1:0]       st;
    } force_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [hcpf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hcpf_pkg::CFG_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [hcpf_pkg::POS_W-1:0] s_a_x = '0, s_a_y = '0, s_a_z = '0;
    logic signed [hcpf_pkg::POS_W-1:0] s_b_x = '0, s_b_y = '0, s_b_z = '0;
    logic [hcpf_pkg::RAD_W-1:0] s_radius_a = '0, s_radius_b = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [hcpf_pkg::FORCE_W-1:0] m_force_x, m_force_y, m_force_z;
    logic [hcpf_pkg::STATUS_W-1:0] m_status;

    // copy of the register file used by the force model
    logic [hcpf_pkg::CFG_W-1:0] energy_q = hcpf_pkg::DEFORMATION_RESET;
    logic                       cutoff_on_q = 1'b0;
    logic [hcpf_pkg::CFG_W-1:0] cutoff_q = hcpf_pkg::CUTOFF_RESET;

    pair_t  pair_q[$];
    force_t force_q[$];
    int     send_idle = 0, recv_idle = 0;
    int     errors = 0, checked = 0, n_sat = 0, n_coin = 0, n_contact = 0;
    int     stuck = 0;

    always #10 aclk = ~aclk;

    hertz_contact_pair_force #(.DIMENSIONS(DIMS)) dut (.*);

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        for (int k = 31; k >= 0; k--) begin
            b = r | (64'd1 << k);
            if (b * b <= v && b < 64'h1_0000_0000)
                r = b;
        end
        return r;
    endfunction

    // expected force on the first cell for one pair
    function automatic force_t contact_force(pair_t p);
        logic signed [63:0] dif[3];
        logic [63:0]  mag[3];
        logic [64:0]  acc;
        logic [63:0]  s, rs, dd, dl, re, dv, mm, uu, lim;
        logic [127:0] pr;
        force_t f;
        f = '{0, 0, 0, hcpf_pkg::STATUS_OK};
        dif[0] = 64'(p.bx) - 64'(p.ax);
        dif[1] = (DIMS > 1) ? 64'(p.by) - 64'(p.ay) : 64'sd0;
        dif[2] = (DIMS > 2) ? 64'(p.bz) - 64'(p.az) : 64'sd0;
        acc = 0;
        // saturating sum of squares
        for (int i = 0; i < 3; i++) begin
            mag[i] = dif[i] < 0 ? -dif[i] : dif[i];
            acc += 65'(mag[i] * mag[i]);
            if (acc[64])
                acc = 65'h0_FFFF_FFFF_FFFF_FFFF;
        end
        s = acc[63:0];
        rs = 64'(p.ra) + 64'(p.rb);
        if (cutoff_on_q && s >= 64'(cutoff_q) * 64'(cutoff_q))
            return f;
        if (s == 0) begin
            f.st = hcpf_pkg::STATUS_COINCIDENT;
            return f;
        end
        if (s >= rs * rs)
            return f;
        dd = root64(s);
        dl = rs - dd;
        re = (64'(p.ra) * 64'(p.rb)) / rs;
        dv = energy_q == 0 ? 64'd1 : 64'(energy_q);
        mm = (dl * root64(dl * re)) / dv;
        for (int i = 0; i < 3; i++) begin
            logic [31:0] comp;
            comp = 0;
            if (mag[i] != 0) begin
                uu = (mag[i] << 31) / dd;
                pr = (128'(mm) * 128'(uu)) >> 31;
                lim = dif[i] > 0 ? 64'h8000_0000 : 64'h7FFF_FFFF;
                if (pr > 128'(lim)) begin
                    pr = 128'(lim);
                    f.st = hcpf_pkg::STATUS_SATURATED;
                end
                comp = dif[i] > 0 ? 32'(-pr[63:0]) : pr[31:0];
            end
            if (i == 0) f.fx = comp;
            else if (i == 1) f.fy = comp;
            else f.fz = comp;
        end
        return f;
    endfunction

    // pair driver
    always @(posedge aclk) begin
        pair_t p;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                p = '{s_a_x, s_a_y, s_a_z, s_b_x, s_b_y, s_b_z, s_radius_a, s_radius_b};
                force_q.push_back(contact_force(p));
            end
            if (!s_valid || s_ready) begin
                if (pair_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    p = pair_q.pop_front();
                    {s_a_x, s_a_y, s_a_z} <= {p.ax, p.ay, p.az};
                    {s_b_x, s_b_y, s_b_z} <= {p.bx, p.by, p.bz};
                    s_radius_a <= p.ra;
                    s_radius_b <= p.rb;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // force monitor and checker
    always @(posedge aclk) begin
        force_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (force_q.size() == 0) begin
                    $error("force transfer with nothing expected");
                    errors++;
                end else begin
                    e = force_q.pop_front();
                    checked++;
                    if (e.st == hcpf_pkg::STATUS_SATURATED) n_sat++;
                    if (e.st == hcpf_pkg::STATUS_COINCIDENT) n_coin++;
                    if (e.fx != 0 || e.fy != 0 || e.fz != 0) n_contact++;
                    if (m_force_x !== e.fx) begin
                        $error("force_x expected %0d got %0d", e.fx, m_force_x);
                        errors++;
                    end
                    if (m_force_y !== e.fy) begin
                        $error("force_y expected %0d got %0d", e.fy, m_force_y);
                        errors++;
                    end
                    if (m_force_z !== e.fz) begin
                        $error("force_z expected %0d got %0d", e.fz, m_force_z);
                        errors++;
                    end
                    if (m_status !== e.st) begin
                        $error("status expected %0d got %0d", e.st, m_status);
                        errors++;
                    end
                end
            end
            m_ready <= $urandom_range(99) >= recv_idle;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn)
            stuck <= 0;
        else if (stuck >= STUCK_MAX) begin
            $display("Verification failed");
            $finish;
        end else
            stuck <= stuck + 1;
    end

    task automatic write_reg(hcpf_pkg::cfg_index_t idx, logic [hcpf_pkg::CFG_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            hcpf_pkg::CFG_DEFORMATION_ENERGY: energy_q = val;
            hcpf_pkg::CFG_USE_CUTOFF:         cutoff_on_q = val[0];
            hcpf_pkg::CFG_CUTOFF_LENGTH:      cutoff_q = val;
            default: ;
        endcase
    endtask

    // wait until the pipeline has returned every force
    task automatic drain();
        wait (pair_q.size() == 0 && !s_valid && force_q.size() == 0);
        @(posedge aclk);
    endtask

    function automatic pair_t mk_pair(int ax, int ay, int az, int bx, int by, int bz,
                                      int ra, int rb);
        pair_t p;
        p = '{ax, ay, az, bx, by, bz, ra[RW-1:0], rb[RW-1:0]};
        return p;
    endfunction

    // mostly overlapping pairs at a random scale, some noise and coincident pairs
    function automatic pair_t random_pair();
        pair_t p;
        int sh, kind;
        logic signed [hcpf_pkg::POS_W-1:0] span;
        kind = $urandom_range(9);
        sh = $urandom_range(30, 2);
        p.ax = $urandom;
        p.ay = $urandom;
        p.az = $urandom;
        p.ra = RW'($urandom);
        p.rb = RW'($urandom);
        if (kind == 0) begin
            {p.bx, p.by, p.bz} = {$urandom, $urandom, $urandom};
        end else if (kind == 1) begin
            {p.bx, p.by, p.bz} = {p.ax, p.ay, p.az};
        end else begin
            span = 32'sd1 <<< (sh - 1);
            p.ax = p.ax >>> 1;
            p.ay = p.ay >>> 1;
            p.az = p.az >>> 1;
            p.bx = p.ax + ($signed($urandom) % span);
            p.by = p.ay + ($signed($urandom) % span);
            p.bz = p.az + ($signed($urandom) % span);
            p.ra = RW'($urandom_range(32'h7FFF_FFFF >> (31 - sh)));
            p.rb = RW'($urandom_range(32'h7FFF_FFFF >> (31 - sh)));
        end
        return p;
    endfunction

    task automatic run_random(int n);
        repeat (n) pair_q.push_back(random_pair());
        drain();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed pairs under reset configuration
        pair_q.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));
        pair_q.push_back(mk_pair(5, 6, 7, 5, 6, 7, 65536, 65536));
        pair_q.push_back(mk_pair(0, 0, 0, 65536, 0, 0, 65536, 65536));
        pair_q.push_back(mk_pair(0, 0, 0, -65536, 0, 0, 65536, 65536));
        pair_q.push_back(mk_pair(0, 0, 0, 0, 65536, 0, 65536, 65536));
        pair_q.push_back(mk_pair(0, 0, 0, 0, -65536, 0, 65536, 65536));
        pair_q.push_back(mk_pair(0, 0, 0, 0, 0, 65536, 65536, 65536));
        pair_q.push_back(mk_pair(0, 0, 0, 0, 0, -65536, 65536, 65536));
        pair_q.push_back(mk_pair(0, 0, 0, 40000, 30000, 20000, 65536, 32768));
        pair_q.push_back(mk_pair(0, 0, 0, 300000, 0, 0, 65536, 65536));
        pair_q.push_back(mk_pair(0, 0, 0, 131072, 0, 0, 65536, 65536));
        pair_q.push_back(mk_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pair_q.push_back(mk_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pair_q.push_back(mk_pair(0, 0, 0, 1, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pair_q.push_back(mk_pair(0, 0, 0, 1, -1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pair_q.push_back(mk_pair(-1, -1, -1, 0, 0, 0, 0, 32'h7FFF_FFFF));
        pair_q.push_back(mk_pair(100, 0, 0, 0, 0, 0, 1, 1));
        pair_q.push_back(mk_pair(0, 0, 0, 2, 0, 0, 1, 2));
        drain();

        // strong stiffness, cutoff enabled
        write_reg(hcpf_pkg::CFG_DEFORMATION_ENERGY, 32'd1);
        write_reg(hcpf_pkg::CFG_USE_CUTOFF, 32'd1);
        write_reg(hcpf_pkg::CFG_CUTOFF_LENGTH, 32'h0010_0000);
        pair_q.push_back(mk_pair(0, 0, 0, 32'h0010_0000, 0, 0, 32'h7FFF_FFFF, 0));
        pair_q.push_back(mk_pair(0, 0, 0, 32'h000F_FFFF, 0, 0, 32'h7FFF_FFFF, 0));
        send_idle = 33;
        recv_idle = 83;
        run_random(160);

        // cutoff at zero kills every pair
        write_reg(hcpf_pkg::CFG_CUTOFF_LENGTH, 32'd0);
        run_random(10);

        // weakest stiffness, cutoff off but at its maximum
        write_reg(hcpf_pkg::CFG_DEFORMATION_ENERGY, 32'hFFFF_FFFF);
        write_reg(hcpf_pkg::CFG_USE_CUTOFF, 32'd0);
        write_reg(hcpf_pkg::CFG_CUTOFF_LENGTH, 32'hFFFF_FFFF);
        send_idle = 83;
        recv_idle = 33;
        run_random(160);

        // zero energy, cutoff at maximum, full throughput
        write_reg(hcpf_pkg::CFG_DEFORMATION_ENERGY, 32'd0);
        write_reg(hcpf_pkg::CFG_USE_CUTOFF, 32'd1);
        send_idle = 0;
        recv_idle = 0;
        run_random(110);

        // mid stiffness with a random cutoff
        write_reg(hcpf_pkg::CFG_DEFORMATION_ENERGY, $urandom);
        write_reg(hcpf_pkg::CFG_CUTOFF_LENGTH, $urandom_range(32'h0100_0000));
        run_random(110);

        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("checked %0d forces: %0d in contact, %0d saturated, %0d coincident",
                 checked, n_contact, n_sat, n_coin);
        $display("stiffness and cutoff swept across extremes with varied flow control");
        if (errors == 0 && force_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/hcpf_pkg.sv
hdl/hcpf_delay.sv
hdl/hcpf_sqrt.sv
hdl/hcpf_div.sv
hdl/hertz_contact_pair_force.sv
tb/tb.sv
